@@ hdl/absolute_encoder_read_validator_assert.svh @@
// assertion macros for the encoder read validator checker
`ifndef ABSOLUTE_ENCODER_READ_VALIDATOR_ASSERT_SVH
`define ABSOLUTE_ENCODER_READ_VALIDATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define AERVL_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("encoder validator check failed");

// next-cycle implication, disabled during reset
`define AERVL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("encoder validator check failed");

`endif

@@ hdl/aervl_pkg.sv @@
// shared types and constants for the encoder read validator
`default_nettype none

package aervl_pkg;

   localparam int RAW_W    = 16;
   localparam int ANGLE_W  = 16;
   localparam int STATUS_W = 2;
   localparam int THRESH_W = 15;
   localparam int CSR_AW   = 1;
   localparam int CSR_DW   = 15;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_FRESH    = 2'd0,
      STATUS_PARITY   = 2'd1,
      STATUS_MISMATCH = 2'd2
   } status_type;

   typedef enum logic [CSR_AW-1:0] {
      CSR_THRESHOLD = 1'd0,
      CSR_PARITY_EN = 1'd1
   } csr_index_type;

   localparam logic [THRESH_W-1:0] THRESH_RESET    = 15'd2;
   localparam logic                PARITY_EN_RESET = 1'b1;

endpackage

`default_nettype wire

@@ hdl/aervl_lane.sv @@
// one reading lane: bit reversal, position extraction and parity
`default_nettype none

module aervl_lane #(
   parameter int RES_BITS = 15
) (
   input  wire logic [aervl_pkg::RAW_W-1:0] raw,
   output logic      [RES_BITS-1:0]         pos,
   output logic                             parity_odd
);

   logic [aervl_pkg::RAW_W-1:0] rev;

   always_comb begin
      for (int i = 0; i < aervl_pkg::RAW_W; i++) begin
         rev[i] = raw[aervl_pkg::RAW_W-1-i];
      end
   end

   assign pos        = rev[RES_BITS-1:0];
   assign parity_odd = ^rev[RES_BITS:0];

endmodule

`default_nettype wire

@@ hdl/aervl_merge.sv @@
// merge stage: angle mapping, wrapped distance check and held angle
`default_nettype none

module aervl_merge #(
   parameter int RES_BITS = 15
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [RES_BITS-1:0]               pos1,
   input  wire logic [RES_BITS-1:0]               pos2,
   input  wire logic                              parity_odd1,
   input  wire logic [aervl_pkg::THRESH_W-1:0]    threshold,
   input  wire logic                              parity_en,
   input  wire logic                              update,
   output logic      [aervl_pkg::ANGLE_W-1:0]     angle,
   output aervl_pkg::status_type                  status
);

   localparam logic [RES_BITS:0] FULL_V = {1'b1, {RES_BITS{1'b0}}};
   localparam logic [RES_BITS:0] HALF_V = FULL_V >> 1;

   logic [aervl_pkg::ANGLE_W-1:0] last_angle_ff;
   logic [aervl_pkg::ANGLE_W-1:0] last_angle_in;
   logic [RES_BITS-1:0]           diff_abs;
   logic [RES_BITS-1:0]           delta;
   logic [aervl_pkg::ANGLE_W-1:0] fresh_angle;

   always_comb begin
      diff_abs = (pos1 >= pos2) ? (pos1 - pos2) : (pos2 - pos1);
      if ({1'b0, diff_abs} > HALF_V) begin
         delta = RES_BITS'(FULL_V - {1'b0, diff_abs});
      end else begin
         delta = diff_abs;
      end
      if ({1'b0, pos1} > HALF_V) begin
         fresh_angle = aervl_pkg::ANGLE_W'(pos1) - aervl_pkg::ANGLE_W'(FULL_V);
      end else begin
         fresh_angle = aervl_pkg::ANGLE_W'(pos1);
      end
      if (parity_en && !parity_odd1) begin
         status = aervl_pkg::STATUS_PARITY;
         angle  = last_angle_ff;
      end else if (aervl_pkg::THRESH_W'(delta) > threshold) begin
         status = aervl_pkg::STATUS_MISMATCH;
         angle  = last_angle_ff;
      end else begin
         status = aervl_pkg::STATUS_FRESH;
         angle  = fresh_angle;
      end
      last_angle_in = update ? angle : last_angle_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_angle_ff <= '0;
      end else begin
         last_angle_ff <= last_angle_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/absolute_encoder_read_validator.sv @@
// top level of the encoder read validator
// Validates two raw readings of a parallel absolute encoder per request and returns a
// signed angle (LSB = one encoder tick) with a status code: fresh, held on parity
// failure of the first reading, or held because the two readings differ by more than
// the threshold (wrapped distance). A request is captured in a register behind the
// lanes, and its result then moves into the output register, from which it can be
// taken. One request is taken every cycle while the result side keeps up. Both
// readings are decoded in parallel lanes; the merge stage holds the last angle, so
// results are produced strictly in order. Registers: index 0 threshold (reset 2),
// index 1 parity enable (reset 1); write them only while no request is in flight.
`default_nettype none

module absolute_encoder_read_validator #(
   parameter int RESOLUTION_BITS = 15
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic        [aervl_pkg::RAW_W-1:0]   req_first_raw,
   input  wire logic        [aervl_pkg::RAW_W-1:0]   req_second_raw,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed      [aervl_pkg::ANGLE_W-1:0] rsp_angle_ticks,
   output logic             [aervl_pkg::STATUS_W-1:0] rsp_status,
   input  wire logic                                 csr_we,
   input  wire logic        [aervl_pkg::CSR_AW-1:0]  csr_addr,
   input  wire logic        [aervl_pkg::CSR_DW-1:0]  csr_wdata
);

   logic                           lane1_parity;
   logic                           lane2_parity;
   logic [RESOLUTION_BITS-1:0]     lane1_pos;
   logic [RESOLUTION_BITS-1:0]     lane2_pos;

   logic                           s1_valid_ff, s1_valid_in;
   logic [RESOLUTION_BITS-1:0]     s1_pos1_ff, s1_pos1_in;
   logic [RESOLUTION_BITS-1:0]     s1_pos2_ff, s1_pos2_in;
   logic                           s1_par_ff, s1_par_in;

   logic                           out_valid_ff, out_valid_in;
   logic [aervl_pkg::ANGLE_W-1:0]  out_angle_ff, out_angle_in;
   logic [aervl_pkg::STATUS_W-1:0] out_status_ff, out_status_in;

   logic [aervl_pkg::THRESH_W-1:0] thresh_ff, thresh_in;
   logic                           par_en_ff, par_en_in;

   logic                           out_adv;
   logic                           s1_adv;
   logic                           s1_move;
   logic [aervl_pkg::ANGLE_W-1:0]  merge_angle;
   aervl_pkg::status_type          merge_status;

   aervl_lane #(.RES_BITS(RESOLUTION_BITS)) u_lane1 (
      .raw        (req_first_raw),
      .pos        (lane1_pos),
      .parity_odd (lane1_parity)
   );

   aervl_lane #(.RES_BITS(RESOLUTION_BITS)) u_lane2 (
      .raw        (req_second_raw),
      .pos        (lane2_pos),
      .parity_odd (lane2_parity)
   );

   aervl_merge #(.RES_BITS(RESOLUTION_BITS)) u_merge (
      .clock       (clock),
      .reset       (reset),
      .pos1        (s1_pos1_ff),
      .pos2        (s1_pos2_ff),
      .parity_odd1 (s1_par_ff),
      .threshold   (thresh_ff),
      .parity_en   (par_en_ff),
      .update      (s1_move),
      .angle       (merge_angle),
      .status      (merge_status)
   );

   assign out_adv   = !out_valid_ff || rsp_ready;
   assign s1_adv    = !s1_valid_ff || out_adv;
   assign s1_move   = s1_valid_ff && out_adv;
   assign req_ready = s1_adv;

   always_comb begin
      s1_valid_in = s1_adv ? req_valid : s1_valid_ff;
      s1_pos1_in  = s1_adv ? lane1_pos : s1_pos1_ff;
      s1_pos2_in  = s1_adv ? lane2_pos : s1_pos2_ff;
      s1_par_in   = s1_adv ? (lane1_parity ^ lane2_parity ^ lane2_parity) : s1_par_ff;

      out_valid_in  = out_adv ? s1_valid_ff : out_valid_ff;
      out_angle_in  = s1_move ? merge_angle : out_angle_ff;
      out_status_in = s1_move ? aervl_pkg::STATUS_W'(merge_status) : out_status_ff;

      thresh_in = thresh_ff;
      par_en_in = par_en_ff;
      if (csr_we) begin
         case (csr_addr)
            aervl_pkg::CSR_THRESHOLD: thresh_in = csr_wdata[aervl_pkg::THRESH_W-1:0];
            aervl_pkg::CSR_PARITY_EN: par_en_in = csr_wdata[0];
            default: begin
               thresh_in = thresh_ff;
               par_en_in = par_en_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         thresh_ff    <= aervl_pkg::THRESH_RESET;
         par_en_ff    <= aervl_pkg::PARITY_EN_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         thresh_ff    <= thresh_in;
         par_en_ff    <= par_en_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pos1_ff    <= s1_pos1_in;
      s1_pos2_ff    <= s1_pos2_in;
      s1_par_ff     <= s1_par_in;
      out_angle_ff  <= out_angle_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_angle_ticks = out_angle_ff;
   assign rsp_status      = out_status_ff;

endmodule

`default_nettype wire

@@ hdl/aervl_checker.sv @@
// port-level checker for the encoder read validator and its bind
`default_nettype none

`include "absolute_encoder_read_validator_assert.svh"

module aervl_checker #(
   parameter int RES_BITS = 15
) (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_ready,
   input wire logic signed [aervl_pkg::ANGLE_W-1:0] rsp_angle_ticks,
   input wire logic        [aervl_pkg::STATUS_W-1:0] rsp_status
);

   localparam int HALF = 1 << (RES_BITS - 1);

   logic [aervl_pkg::ANGLE_W-1:0] last_seen_ff;
   logic [aervl_pkg::ANGLE_W-1:0] last_seen_in;
   logic                          rsp_take;
   logic                          rsp_held;
   logic                          rsp_fresh;
   logic                          rsp_in_range;

   assign rsp_take  = rsp_valid && rsp_ready;
   assign rsp_fresh = rsp_status == aervl_pkg::STATUS_FRESH;
   assign rsp_held  = rsp_status == aervl_pkg::STATUS_PARITY ||
                      rsp_status == aervl_pkg::STATUS_MISMATCH;
   assign rsp_in_range = int'(rsp_angle_ticks) <= HALF && int'(rsp_angle_ticks) > -HALF;
   assign last_seen_in = rsp_take ? rsp_angle_ticks : last_seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_seen_ff <= '0;
      end else begin
         last_seen_ff <= last_seen_in;
      end
   end

   // held results repeat the angle last delivered
   `AERVL_ASSERT_NOW(a_held_repeats, rsp_take && rsp_held, rsp_angle_ticks == last_seen_ff)
   // fresh angles stay within one signed turn
   `AERVL_ASSERT_NOW(a_fresh_range, rsp_valid && rsp_fresh, rsp_in_range)
   // only defined status codes appear
   `AERVL_ASSERT_NOW(a_status_code, rsp_valid, rsp_fresh || rsp_held)
   // stalled result holds
   `AERVL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_angle_ticks) && $stable(rsp_status))

endmodule

bind absolute_encoder_read_validator aervl_checker #(
   .RES_BITS (RESOLUTION_BITS)
) u_aervl_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_angle_ticks (rsp_angle_ticks),
   .rsp_status      (rsp_status)
);

`default_nettype wire
